@@ hdl/mws_pkg.sv @@
// ----------------------------------------------------------------------------
// mws_pkg
// Shared constants, codes and lookup tables of the eight-voice wavetable
// synthesizer.
// ----------------------------------------------------------------------------
package mws_pkg;

    localparam int VOICES_DEFAULT = 8;

    // payload widths
    localparam int CHAN_W   = 4;
    localparam int STATUS_W = 4;
    localparam int DATA_W   = 8;
    localparam int SAMPLE_W = 14;

    // voice state widths
    localparam int PHASE_W = 24;
    localparam int VOL_W   = 7;
    localparam int NOTE_W  = 7;
    localparam int BANK_W  = 4;
    localparam int STEP_W  = 23;
    localparam int WAVE_W  = 5;
    localparam int PROD_W  = 13;

    // control frame
    localparam int FRAME_W = 9;
    localparam logic [FRAME_W-1:0] FRAME_LEN_RESET = 9'd315;
    localparam logic [VOL_W-1:0]   DECAY_STEP      = 7'd4;
    localparam logic [VOL_W-1:0]   NOTE_ON_VOL_MASK = 7'h7c;

    // apb register map
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_LENGTH = 1'd0;

    // item kinds
    localparam logic KIND_MIDI   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // midi status nibbles
    localparam logic [STATUS_W-1:0] ST_NOTE_OFF   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_NOTE_ON    = 4'd9;
    localparam logic [STATUS_W-1:0] ST_CONTROLLER = 4'd11;
    localparam logic [STATUS_W-1:0] ST_PROGRAM    = 4'd12;

    // controller numbers that silence a voice
    localparam logic [DATA_W-1:0] CC_ALL_SOUND_OFF = 8'd120;
    localparam logic [DATA_W-1:0] CC_ALL_NOTES_OFF = 8'd123;

    // phase increment per note
    localparam logic [STEP_W-1:0] STEP_ROM [128] = '{
        23'd3110,    23'd3295,    23'd3491,    23'd3699,
        23'd3919,    23'd4152,    23'd4399,    23'd4660,
        23'd4937,    23'd5231,    23'd5542,    23'd5872,
        23'd6221,    23'd6591,    23'd6983,    23'd7398,
        23'd7838,    23'd8304,    23'd8797,    23'd9321,
        23'd9875,    23'd10462,   23'd11084,   23'd11743,
        23'd12441,   23'd13181,   23'd13965,   23'd14795,
        23'd15675,   23'd16607,   23'd17595,   23'd18641,
        23'd19750,   23'd20924,   23'd22168,   23'd23486,
        23'd24883,   23'd26363,   23'd27930,   23'd29591,
        23'd31351,   23'd33215,   23'd35190,   23'd37282,
        23'd39499,   23'd41848,   23'd44336,   23'd46973,
        23'd49766,   23'd52725,   23'd55860,   23'd59182,
        23'd62701,   23'd66429,   23'd70380,   23'd74565,
        23'd78998,   23'd83696,   23'd88673,   23'd93945,
        23'd99532,   23'd105450,  23'd111721,  23'd118364,
        23'd125402,  23'd132859,  23'd140759,  23'd149129,
        23'd157997,  23'd167392,  23'd177345,  23'd187891,
        23'd199063,  23'd210900,  23'd223441,  23'd236728,
        23'd250804,  23'd265718,  23'd281518,  23'd298258,
        23'd315993,  23'd334783,  23'd354691,  23'd375782,
        23'd398127,  23'd421801,  23'd446882,  23'd473455,
        23'd501608,  23'd531436,  23'd563036,  23'd596516,
        23'd631987,  23'd669567,  23'd709381,  23'd751563,
        23'd796254,  23'd843601,  23'd893765,  23'd946911,
        23'd1003217, 23'd1062871, 23'd1126073, 23'd1193033,
        23'd1263974, 23'd1339134, 23'd1418763, 23'd1503127,
        23'd1592507, 23'd1687203, 23'd1787529, 23'd1893821,
        23'd2006434, 23'd2125742, 23'd2252146, 23'd2386065,
        23'd2527948, 23'd2678268, 23'd2837526, 23'd3006254,
        23'd3185015, 23'd3374406, 23'd3575058, 23'd3787642,
        23'd4012867, 23'd4251485, 23'd4504291, 23'd4772130
    };

    // wave shapes, sixteen 4-bit entries per bank, entry 0 in the low nibble
    localparam logic [63:0] SHAPE_BANK0 = 64'h0015_07C8_35EA_CEE9;
    localparam logic [63:0] SHAPE_BANK1 = 64'h2500_2158_7ECE_EBA9;
    localparam logic [63:0] SHAPE_BANK2 = 64'h3125_38CB_446A_8CED;
    localparam logic [63:0] SHAPE_BANK3 = 64'h9526_2EEB_8540_3DEA;
    localparam logic [63:0] SHAPE_BANK4 = 64'h129D_EDB8_4211_4AE9;
    localparam logic [63:0] SHAPE_BANK5 = 64'h7337_2059_66CE_97BB;

    function automatic logic [3:0] shape_entry(input logic [BANK_W-1:0] bank,
                                               input logic [3:0] pos);
        logic [63:0] row;
        unique case (bank)
            4'd1:    row = SHAPE_BANK1;
            4'd2:    row = SHAPE_BANK2;
            4'd3:    row = SHAPE_BANK3;
            4'd4:    row = SHAPE_BANK4;
            4'd5:    row = SHAPE_BANK5;
            default: row = SHAPE_BANK0;
        endcase
        return row[{pos, 2'b00} +: 4];
    endfunction

endpackage

@@ hdl/mws_item_if.sv @@
// ----------------------------------------------------------------------------
// mws_item_if
// Input channel: a midi message or a sample request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mws_item_if;

    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [mws_pkg::CHAN_W-1:0]         midi_channel;
    logic [mws_pkg::STATUS_W-1:0]       midi_status;
    logic [mws_pkg::DATA_W-1:0]         data_one;
    logic [mws_pkg::DATA_W-1:0]         data_two;

    modport source
    (
        output valid,
        output kind,
        output midi_channel,
        output midi_status,
        output data_one,
        output data_two,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  kind,
        input  midi_channel,
        input  midi_status,
        input  data_one,
        input  data_two,
        output ready
    );

endinterface

@@ hdl/mws_result_if.sv @@
// ----------------------------------------------------------------------------
// mws_result_if
// Output channel: one mixed audio sample per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mws_result_if;

    logic                               valid;
    logic                               ready;
    logic signed [mws_pkg::SAMPLE_W-1:0] sample;
    logic                               frame_began;

    modport source
    (
        output valid,
        output sample,
        output frame_began,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  sample,
        input  frame_began,
        output ready
    );

endinterface

@@ hdl/midi_wavetable_synth_8ch.sv @@
// midi: a midi message is applied to voice state at its transfer
// sample: a request runs the voice sequencer, drains the pipeline, then presents the result
// sequencing: no new item is accepted until the sample result is loaded; the voice
// sequencer visits one voice per cycle through a shared phase adder and multiplier
// reset: asynchronous, active low; all voices silent, frame counter zero,
// frame_length back to 315
// ----------------------------------------------------------------------------
// midi_wavetable_synth_8ch
// Eight-voice wavetable synthesizer: midi messages update voice state, sample
// requests advance all voices and return the mixed mono sample.
// ----------------------------------------------------------------------------
module midi_wavetable_synth_8ch
#(
    parameter int VOICES = mws_pkg::VOICES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mws_pkg::PADDR_W-1:0]         paddr,
    input  logic [mws_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mws_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,

    mws_item_if.sink                            item_in,
    mws_result_if.source                        result_out
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACC_W = mws_pkg::PROD_W + IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_VOICE = IDX_W'(VOICES - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (mws_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // voice state
    logic [mws_pkg::PHASE_W-1:0] phase_reg [VOICES];
    logic [mws_pkg::VOL_W-1:0]   volume_reg [VOICES];
    logic [mws_pkg::NOTE_W-1:0]  note_reg [VOICES];
    logic [mws_pkg::BANK_W-1:0]  bank_reg [VOICES];
    logic                        held_reg [VOICES];

    logic [mws_pkg::FRAME_W-1:0] frame_len_reg;
    logic [mws_pkg::FRAME_W-1:0] countdown_reg, countdown_next;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             frame_step_reg;
    logic             began_reg;

    // pipeline: voice update -> multiply -> accumulate
    logic                               s1_vld_reg;
    logic signed [mws_pkg::WAVE_W-1:0]  wave_reg;
    logic [mws_pkg::VOL_W-1:0]          gain_reg;
    logic                               s2_vld_reg;
    logic signed [mws_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]            acc_reg;

    logic                                out_valid_reg;
    logic signed [mws_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                out_began_reg;

    logic in_xfer, midi_xfer, sample_xfer, cfg_wr, run, load_out;
    logic chan_ok;
    logic [IDX_W-1:0] chan_idx;

    logic [mws_pkg::VOL_W-1:0]   vol_cur, vol_dec;
    logic [mws_pkg::PHASE_W-1:0] phase_new;
    logic                        voice_on;
    logic [3:0]                  shape_val;
    logic signed [ACC_W-1:0]     sum_sat;

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[mws_pkg::PADDR_W-1:2] == mws_pkg::REG_FRAME_LENGTH);

    always_comb
    begin
        prdata = '0;
        if (paddr[mws_pkg::PADDR_W-1:2] == mws_pkg::REG_FRAME_LENGTH)
        begin
            prdata = mws_pkg::APB_DATA_W'(frame_len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= mws_pkg::FRAME_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            frame_len_reg <= pwdata[mws_pkg::FRAME_W-1:0];
        end
    end

    // handshake
    assign item_in.ready = (state_reg == S_IDLE);
    assign in_xfer       = item_in.valid && item_in.ready;
    assign midi_xfer     = in_xfer && (item_in.kind == mws_pkg::KIND_MIDI);
    assign sample_xfer   = in_xfer && (item_in.kind == mws_pkg::KIND_SAMPLE);
    assign run           = (state_reg == S_RUN);
    assign load_out      = (state_reg == S_DONE) && (!out_valid_reg || result_out.ready);

    assign chan_ok  = ({1'b0, item_in.midi_channel} < (mws_pkg::CHAN_W + 1)'(VOICES));
    assign chan_idx = item_in.midi_channel[IDX_W-1:0];

    // shared voice unit
    always_comb
    begin
        vol_cur = volume_reg[idx_reg];
        vol_dec = vol_cur;
        if (frame_step_reg && !held_reg[idx_reg] && (vol_cur != '0))
        begin
            vol_dec = (vol_cur >= mws_pkg::DECAY_STEP) ? (vol_cur - mws_pkg::DECAY_STEP) : '0;
        end
        voice_on  = (vol_dec != '0);
        phase_new = phase_reg[idx_reg]
                    + mws_pkg::PHASE_W'(mws_pkg::STEP_ROM[note_reg[idx_reg]]);
        shape_val = mws_pkg::shape_entry(bank_reg[idx_reg],
                                         phase_new[mws_pkg::PHASE_W-1 -: 4]);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        countdown_next = countdown_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_xfer)
                begin
                    // reload on frame start, then count this sample
                    if (countdown_reg == '0)
                    begin
                        countdown_next = ((frame_len_reg == '0) ? mws_pkg::FRAME_W'(1)
                                                                : frame_len_reg)
                                         - mws_pkg::FRAME_W'(1);
                    end
                    else
                    begin
                        countdown_next = countdown_reg - mws_pkg::FRAME_W'(1);
                    end
                    idx_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (idx_reg == LAST_VOICE)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            countdown_reg  <= '0;
            frame_step_reg <= 1'b0;
            began_reg      <= 1'b0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            countdown_reg <= countdown_next;
            if (sample_xfer)
            begin
                frame_step_reg <= (countdown_reg == '0);
                began_reg      <= (countdown_reg == '0);
            end
            s1_vld_reg <= run;
            s2_vld_reg <= s1_vld_reg;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // voice state writes: midi in idle, sequencer during the run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                phase_reg[v]  <= '0;
                volume_reg[v] <= '0;
                note_reg[v]   <= '0;
                bank_reg[v]   <= '0;
                held_reg[v]   <= 1'b0;
            end
        end
        else if (run)
        begin
            volume_reg[idx_reg] <= vol_dec;
            if (voice_on)
            begin
                phase_reg[idx_reg] <= phase_new;
            end
        end
        else if (midi_xfer && chan_ok)
        begin
            unique case (item_in.midi_status)
                mws_pkg::ST_NOTE_OFF:
                begin
                    held_reg[chan_idx] <= 1'b0;
                end
                mws_pkg::ST_NOTE_ON:
                begin
                    note_reg[chan_idx]   <= item_in.data_one[mws_pkg::NOTE_W-1:0];
                    phase_reg[chan_idx]  <= '0;
                    volume_reg[chan_idx] <= item_in.data_two[mws_pkg::VOL_W-1:0]
                                            & mws_pkg::NOTE_ON_VOL_MASK;
                    held_reg[chan_idx]   <= 1'b1;
                end
                mws_pkg::ST_CONTROLLER:
                begin
                    if ((item_in.data_one == mws_pkg::CC_ALL_SOUND_OFF)
                        || (item_in.data_one == mws_pkg::CC_ALL_NOTES_OFF))
                    begin
                        held_reg[chan_idx]   <= 1'b0;
                        volume_reg[chan_idx] <= '0;
                    end
                end
                mws_pkg::ST_PROGRAM:
                begin
                    bank_reg[chan_idx] <= item_in.data_one[mws_pkg::DATA_W-1 -: mws_pkg::BANK_W];
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath: wave pick, multiply, accumulate
    always_ff @(posedge clk)
    begin
        if (run)
        begin
            if (voice_on && phase_new[mws_pkg::PHASE_W-1])
            begin
                wave_reg <= $signed({1'b0, shape_val}) - mws_pkg::WAVE_W'(8);
            end
            else
            begin
                wave_reg <= '0;
            end
            gain_reg <= vol_dec;
        end
        if (s1_vld_reg)
        begin
            prod_reg <= wave_reg * $signed({1'b0, gain_reg});
        end
        if (sample_xfer)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W - mws_pkg::PROD_W){prod_reg[mws_pkg::PROD_W-1]}},
                                  prod_reg};
        end
        if (load_out)
        begin
            sample_reg    <= sum_sat[mws_pkg::SAMPLE_W-1:0];
            out_began_reg <= began_reg;
        end
    end

    always_comb
    begin
        priority if (acc_reg > SAT_HI)
        begin
            sum_sat = SAT_HI;
        end
        else if (acc_reg < SAT_LO)
        begin
            sum_sat = SAT_LO;
        end
        else
        begin
            sum_sat = acc_reg;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.sample      = sample_reg;
    assign result_out.frame_began = out_began_reg;

endmodule

@@ hdl/mws_checker.sv @@
// ----------------------------------------------------------------------------
// mws_checker
// Port-level checks of the synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
module mws_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 in_kind,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [mws_pkg::SAMPLE_W-1:0]  out_sample,
    input logic                                 out_frame_began
);

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    // a sample request occupies the voice sequencer
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_kind == mws_pkg::KIND_SAMPLE) |=> !in_ready)
        else $error("ready high right after a sample request transfer");

    // a midi message leaves the input ready
    a_ready_after_midi: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_kind == mws_pkg::KIND_MIDI) |=> in_ready)
        else $error("ready dropped after a midi transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample)
                                    && $stable(out_frame_began))
        else $error("result changed while stalled");

endmodule

bind midi_wavetable_synth_8ch mws_checker u_mws_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (item_in.valid),
    .in_ready        (item_in.ready),
    .in_kind         (item_in.kind),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .out_sample      (result_out.sample),
    .out_frame_began (result_out.frame_began)
);
